// File: design/agkf_pkg.sv
// ----------------------------------------------------------------------------
// agkf_pkg
// Shared types, constants and helpers of the angle/gyro Kalman filter.
// ----------------------------------------------------------------------------
package agkf_pkg;

	localparam int CfgWidth = 31;
	localparam int ProdWidth = 69;
	localparam int WideWidth = 70;

	localparam logic [CfgWidth-1:0] AngleNoiseReset = 31'd107374;
	localparam logic [CfgWidth-1:0] BiasNoiseReset  = 31'd322123;
	localparam logic [CfgWidth-1:0] MeasNoiseReset  = 31'd1073742;

	localparam logic [1:0] RegAngleNoise = 2'd0;
	localparam logic [1:0] RegBiasNoise  = 2'd1;
	localparam logic [1:0] RegMeasNoise  = 2'd2;

	// Multiply operations of the shared multiplier, in program order.
	typedef enum logic [3:0] {
		OP_RATE  = 4'd0,
		OP_T     = 4'd1,
		OP_INNER = 4'd2,
		OP_BQ    = 4'd3,
		OP_K1I   = 4'd4,
		OP_K0I   = 4'd5,
		OP_K1P0  = 4'd6,
		OP_K1P1  = 4'd7,
		OP_K0P0  = 4'd8,
		OP_K0P1  = 4'd9
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic wb_en;
		op_t  op;
		logic div_start;
		logic div_sel;
		logic div_store;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [WideWidth-1:0] v);
		logic signed [31:0] r;
		if (v > 70'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -70'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: design/agkf_div.sv
// ----------------------------------------------------------------------------
// agkf_div
// Restoring divider for the gains: (p * 2^30) / d, rounded half away from
// zero, saturated to signed 32 bits, zero when d is zero. One bit a cycle.
// ----------------------------------------------------------------------------
module agkf_div import agkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] numer,
	input  logic signed [32:0] denom,
	output logic               done,
	output logic signed [31:0] quot
);

	localparam int QBits = 33;

	logic        busy_q;
	logic        fin_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [32:0] lo_q;
	logic [32:0] q_q;
	logic [32:0] ud_q;
	logic        neg_q;
	logic        zero_q;
	logic        ovf_q;

	logic [32:0] np;
	logic [32:0] ud;
	logic [61:0] nsum;
	logic [33:0] trial;
	logic        take;
	logic        sat;

	always_comb begin
		np = numer[31] ? 33'(-(33'(numer))) : 33'(numer);
		ud = denom[32] ? 33'(-denom) : 33'(denom);
		// Adding half the divisor first gives rounding to nearest.
		nsum = {np[31:0], 30'd0} + 62'(ud >> 1);
		trial = {rem_q, lo_q[32]};
		take = trial >= {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(QBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {4'd0, nsum[61:33]};
			lo_q <= nsum[32:0];
			q_q <= '0;
			ud_q <= ud;
			neg_q <= numer[31] ^ denom[32];
			zero_q <= (denom == '0);
			ovf_q <= ({4'd0, nsum[61:33]} >= ud);
		end else if (busy_q) begin
			rem_q <= take ? 33'(trial - {1'b0, ud_q}) : trial[32:0];
			lo_q <= {lo_q[31:0], 1'b0};
			q_q <= {q_q[31:0], take};
		end
	end

	always_comb begin
		sat = ovf_q | q_q[32] | q_q[31];
		if (zero_q) begin
			quot = '0;
		end else if (neg_q) begin
			quot = sat ? 32'sh80000000 : -$signed(q_q[31:0]);
		end else begin
			quot = sat ? 32'sh7fffffff : $signed(q_q[31:0]);
		end
	end

	assign done = fin_q;

endmodule

// File: design/agkf_dp.sv
// ----------------------------------------------------------------------------
// agkf_dp
// Filter datapath: state and covariance registers, one shared multiplier with
// a rounding write-back stage, the gain divider and the result register.
// ----------------------------------------------------------------------------
module agkf_dp import agkf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [CfgWidth-1:0] angle_noise,
	input  logic [CfgWidth-1:0] bias_noise,
	input  logic [CfgWidth-1:0] meas_noise,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  gyro_rate,
	input  logic [23:0]         time_step,
	output logic signed [31:0]  angle_estimate,
	output logic signed [31:0]  bias_estimate
);

	logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	logic signed [31:0] meas_q, gyro_q;
	logic [23:0]        dt_q;
	logic signed [32:0] t_q;
	logic signed [31:0] k0_q, k1_q;
	logic signed [ProdWidth-1:0] prod_q;
	logic signed [31:0] ang_out_q, bias_out_q;

	logic signed [35:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [32:0] rate;
	logic signed [35:0] inner;
	logic signed [31:0] innov;
	logic signed [32:0] dt_s;
	logic signed [32:0] var_s;
	logic signed [WideWidth-1:0] r24, r30;
	logic signed [31:0] div_q;
	logic               div_done;

	always_comb begin
		dt_s = $signed({9'd0, dt_q});
		rate = 33'(gyro_q) - 33'(bias_q);
		inner = 36'(t_q) - 36'(cab_q) - 36'(cba_q) + $signed({5'd0, angle_noise});
		innov = sat32(70'(meas_q) - 70'(ang_q));
		var_s = 33'(caa_q) + $signed({2'd0, meas_noise});
		// Rounding shift: adding half and shifting arithmetically rounds ties up.
		r24 = (70'(prod_q) + 70'sd8388608) >>> 24;
		r30 = (70'(prod_q) + 70'sd536870912) >>> 30;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_RATE:  begin mul_a = 36'(rate);  mul_b = dt_s; end
			OP_T:     begin mul_a = 36'(cbb_q); mul_b = dt_s; end
			OP_INNER: begin mul_a = inner;      mul_b = dt_s; end
			OP_BQ:    begin mul_a = $signed({5'd0, bias_noise}); mul_b = dt_s; end
			OP_K1I:   begin mul_a = 36'(k1_q);  mul_b = 33'(innov); end
			OP_K0I:   begin mul_a = 36'(k0_q);  mul_b = 33'(innov); end
			OP_K1P0:  begin mul_a = 36'(k1_q);  mul_b = 33'(caa_q); end
			OP_K1P1:  begin mul_a = 36'(k1_q);  mul_b = 33'(cab_q); end
			OP_K0P0:  begin mul_a = 36'(k0_q);  mul_b = 33'(caa_q); end
			OP_K0P1:  begin mul_a = 36'(k0_q);  mul_b = 33'(cab_q); end
			default:  begin mul_a = '0;         mul_b = '0; end
		endcase
	end

	agkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (cmd.div_sel ? cba_q : caa_q),
		.denom  (var_s),
		.done   (div_done),
		.quot   (div_q)
	);

	assign status.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measured_angle;
			gyro_q <= gyro_rate;
			dt_q <= time_step;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.wb_en && cmd.op == OP_T) begin
			t_q <= r24[32:0];
		end
		if (cmd.div_store) begin
			if (cmd.div_sel) begin
				k1_q <= div_q;
			end else begin
				k0_q <= div_q;
			end
		end
		if (cmd.out_load) begin
			ang_out_q <= ang_q;
			bias_out_q <= bias_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q <= '0;
			bias_q <= '0;
			caa_q <= '0;
			cab_q <= '0;
			cba_q <= '0;
			cbb_q <= '0;
		end else if (cmd.wb_en) begin
			case (cmd.op)
				OP_RATE:  ang_q <= sat32(70'(ang_q) + r24);
				OP_INNER: begin
					caa_q <= sat32(70'(caa_q) + r24);
					cab_q <= sat32(70'(cab_q) - 70'(t_q));
					cba_q <= sat32(70'(cba_q) - 70'(t_q));
				end
				OP_BQ:    cbb_q <= sat32(70'(cbb_q) + r24);
				OP_K1I:   bias_q <= sat32(70'(bias_q) + r30);
				OP_K0I:   ang_q <= sat32(70'(ang_q) + r30);
				OP_K1P0:  cba_q <= sat32(70'(cba_q) - r30);
				OP_K1P1:  cbb_q <= sat32(70'(cbb_q) - r30);
				OP_K0P0:  caa_q <= sat32(70'(caa_q) - r30);
				OP_K0P1:  cab_q <= sat32(70'(cab_q) - r30);
				default:  ;
			endcase
		end
	end

	assign angle_estimate = ang_out_q;
	assign bias_estimate = bias_out_q;

endmodule

// File: design/agkf_ctrl.sv
// ----------------------------------------------------------------------------
// agkf_ctrl
// Sequencer of the filter: steps the datapath through the predict multiplies,
// the two gain divisions and the correction multiplies, then hands off a beat.
// ----------------------------------------------------------------------------
module agkf_ctrl import agkf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_WB    = 6'b000100,
		S_DIV   = 6'b001000,
		S_DWAIT = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   sel_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_MUL:   cmd.mul_en = 1'b1;
			S_WB:    cmd.wb_en = 1'b1;
			S_DIV:   cmd.div_start = 1'b1;
			S_DWAIT: cmd.div_store = status.div_done;
			S_OUT:   cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_RATE;
			sel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= OP_RATE;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					case (op_q)
						OP_RATE:  begin op_q <= OP_T;    state_q <= S_MUL; end
						OP_T:     begin op_q <= OP_INNER; state_q <= S_MUL; end
						OP_INNER: begin op_q <= OP_BQ;   state_q <= S_MUL; end
						OP_BQ: begin
							op_q <= OP_K1I;
							sel_q <= 1'b0;
							state_q <= S_DIV;
						end
						OP_K1I:   begin op_q <= OP_K0I;  state_q <= S_MUL; end
						OP_K0I:   begin op_q <= OP_K1P0; state_q <= S_MUL; end
						OP_K1P0:  begin op_q <= OP_K1P1; state_q <= S_MUL; end
						OP_K1P1:  begin op_q <= OP_K0P0; state_q <= S_MUL; end
						OP_K0P0:  begin op_q <= OP_K0P1; state_q <= S_MUL; end
						default:  state_q <= S_OUT;
					endcase
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (status.div_done) begin
						if (sel_q) begin
							state_q <= S_MUL;
						end else begin
							sel_q <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/angle_gyro_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter_core
// Two-state Kalman filter fusing an accelerometer angle with a gyro rate.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  measured_angle, gyro_rate, time_step
//   out      out_valid/out_stall  angle_estimate, bias_estimate
//   cfg      APB write/read       three noise registers at 0x0, 0x4, 0x8
//
// A sample goes from acceptance to its result beat through ten passes through
// the shared multiplier (a multiply, then a rounding write-back), two divisions
// (a start, 33 quotient bits and a finish) and the load of the result.
// A new sample is taken only once the last one has left for the output register.
// Reset clears the filter state and loads the default noise registers.
// A stalled result beat holds in the output register while the next sample
// is already taken and processed; only its hand-off waits for the register.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter_core import agkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] gyro_rate,
	input  logic [23:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] angle_estimate,
	output logic signed [31:0] bias_estimate,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [CfgWidth-1:0] angle_noise_q, bias_noise_q, meas_noise_q;
	logic [1:0]          reg_idx;
	cmd_t                cmd;
	status_t             status;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_noise_q <= AngleNoiseReset;
			bias_noise_q <= BiasNoiseReset;
			meas_noise_q <= MeasNoiseReset;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				RegAngleNoise: angle_noise_q <= pwdata[CfgWidth-1:0];
				RegBiasNoise:  bias_noise_q <= pwdata[CfgWidth-1:0];
				RegMeasNoise:  meas_noise_q <= pwdata[CfgWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegAngleNoise: prdata = {1'b0, angle_noise_q};
			RegBiasNoise:  prdata = {1'b0, bias_noise_q};
			RegMeasNoise:  prdata = {1'b0, meas_noise_q};
			default:       prdata = '0;
		endcase
	end

	agkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	agkf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.angle_noise    (angle_noise_q),
		.bias_noise     (bias_noise_q),
		.meas_noise     (meas_noise_q),
		.measured_angle (measured_angle),
		.gyro_rate      (gyro_rate),
		.time_step      (time_step),
		.angle_estimate (angle_estimate),
		.bias_estimate  (bias_estimate)
	);

endmodule
